@@ hdl/rkrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rkrf_pkg: shared types and constants of the remote key repeat filter
// Holds the request and result records, the event and register codes and
// the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package rkrf_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CFG_W   = 16;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] REPEAT_DELAY_RST   = 16'd300;
    localparam logic [15:0] REPEAT_GAP_RST     = 16'd100;
    localparam logic [7:0]  MAGIC_MODIFIER_RST = 8'hFF;
    localparam logic [7:0]  IGNORED_KEY_RST    = 8'h00;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_REPEAT  = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    typedef enum logic [1:0] {
        CFG_REPEAT_DELAY   = 2'd0,
        CFG_REPEAT_GAP     = 2'd1,
        CFG_MAGIC_MODIFIER = 2'd2,
        CFG_IGNORED_KEY    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       cmd;
        logic [7:0] modifier_code;
        logic [7:0] key_code;
        logic [7:0] release_timeout;
    } t_req;

    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  out_modifier;
        logic [7:0]  out_key;
        logic        last_of_run;
    } t_res;

    typedef struct packed {
        logic [15:0] repeat_delay;
        logic [15:0] repeat_gap;
        logic [7:0]  magic_modifier;
        logic [7:0]  ignored_key;
    } t_cfg;

    // Up to two results caused by one request
    typedef struct packed {
        logic [1:0] num;
        t_res       ev0;
        t_res       ev1;
    } t_emit;

    typedef struct packed {
        logic held_valid;
        logic repeating;
        logic release_pending;
        logic timeout_armed;
    } t_track_status;

endpackage

@@ hdl/rkrf_req_if.sv @@
// ----------------------------------------------------------------------------
// rkrf_req_if: request channel of the remote key repeat filter
// Valid/ready channel carrying key reports and millisecond ticks.
// ----------------------------------------------------------------------------
interface rkrf_req_if import rkrf_pkg::*; ();

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/rkrf_res_if.sv @@
// ----------------------------------------------------------------------------
// rkrf_res_if: result channel of the remote key repeat filter
// Valid/ready channel carrying press, repeat and release events.
// ----------------------------------------------------------------------------
interface rkrf_res_if import rkrf_pkg::*; ();

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/rkrf_track.sv @@
// ----------------------------------------------------------------------------
// rkrf_track: key tracking state and event decision
// Updates the held key, elapsed-time counters and release timeout for one
// request per cycle while i_fire is set and produces the events it causes.
// ----------------------------------------------------------------------------
module rkrf_track import rkrf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  t_req          i_req,
    input  t_cfg          i_cfg,
    output t_emit         o_emit,
    output t_track_status o_status
);

    logic        r_held_valid, n_held_valid;
    logic [7:0]  r_held_modifier, n_held_modifier;
    logic [7:0]  r_held_key, n_held_key;
    logic        r_repeating, n_repeating;
    logic        r_release_pending, n_release_pending;
    logic [15:0] r_since_first, n_since_first;
    logic [15:0] r_since_emit, n_since_emit;
    logic [7:0]  r_idle_count, n_idle_count;
    logic [7:0]  r_timeout_limit, n_timeout_limit;
    logic        r_timeout_armed, n_timeout_armed;

    logic        rel;
    logic        main_ev;
    t_event_kind main_kind;
    logic        is_magic;
    logic        is_new;
    t_res        rel_res;
    t_res        main_res;

    always_comb begin
        n_held_valid      = r_held_valid;
        n_held_modifier   = r_held_modifier;
        n_held_key        = r_held_key;
        n_repeating       = r_repeating;
        n_release_pending = r_release_pending;
        n_since_first     = r_since_first;
        n_since_emit      = r_since_emit;
        n_idle_count      = r_idle_count;
        n_timeout_limit   = r_timeout_limit;
        n_timeout_armed   = r_timeout_armed;
        rel               = 1'b0;
        main_ev           = 1'b0;
        main_kind         = EV_PRESS;
        is_magic = (i_req.modifier_code == i_cfg.magic_modifier) &&
                   (i_req.key_code == i_cfg.ignored_key);
        is_new   = !r_held_valid || (i_req.modifier_code != r_held_modifier) ||
                   (i_req.key_code != r_held_key);

        if (i_req.cmd == CMD_TICK) begin
            if (r_since_first != SAT16) n_since_first = r_since_first + 16'd1;
            if (r_since_emit != SAT16)  n_since_emit  = r_since_emit + 16'd1;
            if (r_timeout_armed) begin
                if (({1'b0, r_idle_count} + 9'd1) < {1'b0, r_timeout_limit}) begin
                    n_idle_count = r_idle_count + 8'd1;
                end else begin
                    // Timeout: release a repeating key and forget it
                    rel               = r_release_pending && r_repeating && r_held_valid;
                    n_held_valid      = 1'b0;
                    n_repeating       = 1'b0;
                    n_release_pending = 1'b0;
                    n_timeout_armed   = 1'b0;
                    n_idle_count      = 8'd0;
                end
            end
        end else begin
            n_idle_count = 8'd0;
            if (!is_magic) begin
                n_timeout_limit = i_req.release_timeout;
                n_timeout_armed = 1'b1;
                if (is_new) begin
                    rel             = r_repeating && r_held_valid;
                    n_held_valid    = 1'b1;
                    n_held_modifier = i_req.modifier_code;
                    n_held_key      = i_req.key_code;
                    n_repeating     = 1'b0;
                    n_since_first   = 16'd0;
                    main_ev         = 1'b1;
                    main_kind       = EV_PRESS;
                end else if ((r_since_first >= i_cfg.repeat_delay) &&
                             (r_since_emit >= i_cfg.repeat_gap)) begin
                    n_repeating = 1'b1;
                    main_ev     = 1'b1;
                    main_kind   = EV_REPEAT;
                end
                if (main_ev) begin
                    n_since_emit      = 16'd0;
                    n_release_pending = 1'b1;
                end
            end
        end

        rel_res.event_kind   = EV_RELEASE;
        rel_res.out_modifier = r_held_modifier;
        rel_res.out_key      = r_held_key;
        rel_res.last_of_run  = !main_ev;

        main_res.event_kind   = main_kind;
        main_res.out_modifier = i_req.modifier_code;
        main_res.out_key      = i_req.key_code;
        main_res.last_of_run  = 1'b1;

        o_emit.num = {1'b0, rel} + {1'b0, main_ev};
        o_emit.ev0 = rel ? rel_res : main_res;
        o_emit.ev1 = main_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid      <= 1'b0;
            r_held_modifier   <= 8'd0;
            r_held_key        <= 8'd0;
            r_repeating       <= 1'b0;
            r_release_pending <= 1'b0;
            r_since_first     <= SAT16;
            r_since_emit      <= SAT16;
            r_idle_count      <= 8'd0;
            r_timeout_limit   <= 8'd0;
            r_timeout_armed   <= 1'b0;
        end else if (i_fire) begin
            r_held_valid      <= n_held_valid;
            r_held_modifier   <= n_held_modifier;
            r_held_key        <= n_held_key;
            r_repeating       <= n_repeating;
            r_release_pending <= n_release_pending;
            r_since_first     <= n_since_first;
            r_since_emit      <= n_since_emit;
            r_idle_count      <= n_idle_count;
            r_timeout_limit   <= n_timeout_limit;
            r_timeout_armed   <= n_timeout_armed;
        end
    end

    assign o_status.held_valid      = r_held_valid;
    assign o_status.repeating       = r_repeating;
    assign o_status.release_pending = r_release_pending;
    assign o_status.timeout_armed   = r_timeout_armed;

endmodule

@@ hdl/rkrf_outq.sv @@
// ----------------------------------------------------------------------------
// rkrf_outq: result queue
// Small register queue taking up to two results per cycle and handing one
// result per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module rkrf_outq import rkrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_emit             i_emit,
    input  logic              i_pop,
    output logic              o_valid,
    output t_res              o_res,
    output logic              o_room,
    output logic [QCNT_W-1:0] o_count
);

    t_res              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [1:0]        push_num;
    logic              pop;
    logic [QPTR_W-1:0] wr_next;

    assign push_num = i_push ? i_emit.num : 2'd0;
    assign pop      = i_pop && (r_count != '0);
    assign wr_next  = r_wr + QPTR_W'(1);

    always_comb begin
        n_rd    = pop ? r_rd + QPTR_W'(1) : r_rd;
        n_wr    = r_wr + QPTR_W'(push_num);
        n_count = r_count + QCNT_W'(push_num) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) r_mem[r_wr]    <= i_emit.ev0;
        if (push_num == 2'd2) r_mem[wr_next] <= i_emit.ev1;
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    // Room for the two results a request may cause
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_count = r_count;

endmodule

@@ hdl/remote_key_repeat_filter_core.sv @@
// ----------------------------------------------------------------------------
// remote_key_repeat_filter_core: remote key repeat filter, top level
// Turns key reports and millisecond ticks into press, repeat and release
// events with auto-repeat throttling and a per-report release timeout.
//
//   channel  dir  handshake        payload
//   i_req    in   valid / ready    cmd, modifier_code, key_code, release_timeout
//   o_res    out  valid / ready    event_kind, out_modifier, out_key, last_of_run
//   cfg      in   i_cfg_we only    i_cfg_idx, i_cfg_data
//
// A request lands in an input register and is decided from there, while the
// queue has room, against the key tracking state; its zero, one or two events
// go into a four-entry result queue, so a request is accepted every cycle
// while the queue has room. The first result passes the input register and
// the result queue before it is valid on o_res.
// The input register holds while the queue has fewer than two free entries;
// a stalled output therefore backs up to i_req.ready once three or more
// results wait and a request sits in the input register.
// Reset is synchronous and active low; it loads the register defaults.
// ----------------------------------------------------------------------------
module remote_key_repeat_filter_core import rkrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rkrf_req_if.sink          i_req,
    rkrf_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_req              r_in;
    logic              fire;
    logic              room;
    t_emit             emit;
    t_track_status     status;
    logic [QCNT_W-1:0] q_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay   <= REPEAT_DELAY_RST;
            r_cfg.repeat_gap     <= REPEAT_GAP_RST;
            r_cfg.magic_modifier <= MAGIC_MODIFIER_RST;
            r_cfg.ignored_key    <= IGNORED_KEY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_DELAY:   r_cfg.repeat_delay   <= i_cfg_data;
                CFG_REPEAT_GAP:     r_cfg.repeat_gap     <= i_cfg_data;
                CFG_MAGIC_MODIFIER: r_cfg.magic_modifier <= i_cfg_data[7:0];
                CFG_IGNORED_KEY:    r_cfg.ignored_key    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Decide the held request when the queue can take its events
    assign fire        = r_in_valid && room;
    assign i_req.ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // Advance the payload only on acceptance
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    rkrf_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (r_in),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_status (status)
    );

    rkrf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_emit  (emit),
        .i_pop   (o_res.ready),
        .o_valid (o_res.valid),
        .o_res   (o_res.data),
        .o_room  (room),
        .o_count (q_count)
    );

`ifndef SYNTHESIS
    a_repeat_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.repeating |-> status.held_valid)
        else $error("repeating set without a held key");

    a_pending_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.release_pending |-> status.timeout_armed)
        else $error("release pending while timeout is not armed");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_fire_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> q_count <= QCNT_W'(QDEPTH))
        else $error("request decided without queue room");
`endif

endmodule
